// ===== sv/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types, codes and the whitespace classifier of the csv field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

    localparam int PENDING_DEPTH_DEF = 32;

    localparam logic [15:0] CH_QUOTE = 16'h0022;
    localparam logic [15:0] CH_COMMA = 16'h002C;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_FIELD = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] ERR_AFTER_QUOTE = 2'd0;
    localparam logic [1:0] ERR_BARE_QUOTE  = 2'd1;
    localparam logic [1:0] ERR_OPEN_QUOTE  = 2'd2;
    localparam logic [1:0] ERR_WS_OVERFLOW = 2'd3;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    // flushes in flight between front and back, at most queue depth plus one
    localparam int FL_W = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ch;
        logic [1:0]  err;
    } t_res;

    typedef struct packed {
        logic flush_done;
    } t_bk_status;

    function automatic logic is_ws(input logic [15:0] c);
        logic r;
        r = (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D)
            || (c == 16'h0085) || (c == 16'h00A0) || (c == 16'h1680)
            || (c >= 16'h2000 && c <= 16'h200A)
            || (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F)
            || (c == 16'h205F) || (c == 16'h3000);
        return r;
    endfunction

endpackage

// ===== sv/cft_ram.sv =====
// ----------------------------------------------------------------------------
// cft_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/cft_queue.sv =====
// ----------------------------------------------------------------------------
// cft_queue
// Two-entry queue of decoded commands between the front and the back.
// ----------------------------------------------------------------------------
module cft_queue #(
    parameter int WIDTH = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_data  = r_slot[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_slot[r_wp] <= i_data;
                r_wp         <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== sv/cft_front.sv =====
// ----------------------------------------------------------------------------
// cft_front
// Accepts input items, runs the quote/field parse state and the trailing
// whitespace buffer, and issues one command per result group to the queue.
// ----------------------------------------------------------------------------
module cft_front
    import cft_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    localparam int CW = $clog2(PENDING_DEPTH + 1),
    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_command,
    input  logic [15:0]   i_char_in,
    input  logic          i_q_full,
    output logic          o_push,
    output t_res          o_res,
    output logic [CW-1:0] o_fcnt,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [15:0]   o_wdata,
    input  t_bk_status    i_bk
);

    typedef enum logic [2:0] {
        M_START,
        M_QUOTED,
        M_PENDQ,
        M_CLOSED,
        M_SKIP
    } t_mode;

    t_mode         r_mode, n_mode;
    logic          r_raw, n_raw;
    logic          r_ce, n_ce;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [FL_W-1:0] r_fl;

    logic          acc;
    logic          push;
    logic          take;
    logic          we;
    logic          clr;
    logic          ws;
    t_res          res;
    logic [CW-1:0] fcnt;

    assign ws = is_ws(i_char_in);

    always_comb begin
        n_mode = r_mode;
        n_raw  = r_raw;
        n_ce   = r_ce;
        n_cnt  = r_cnt;
        push   = 1'b0;
        take   = 1'b0;
        we     = 1'b0;
        clr    = 1'b0;
        res    = '0;
        fcnt   = '0;

        if (i_command == CMD_EOL) begin
            unique case (r_mode)
                M_START, M_PENDQ, M_CLOSED: begin
                    push     = 1'b1;
                    res.kind = KIND_LINE;
                end
                M_QUOTED: begin
                    push     = 1'b1;
                    res.kind = KIND_ERROR;
                    res.err  = ERR_OPEN_QUOTE;
                end
                default: ;
            endcase
            clr = 1'b1;
        end else begin
            unique case (r_mode)
                M_START: begin
                    if (i_char_in == CH_COMMA) begin
                        push     = 1'b1;
                        res.kind = KIND_FIELD;
                        clr      = 1'b1;
                    end else if (i_char_in == CH_QUOTE) begin
                        if (r_raw) begin
                            push     = 1'b1;
                            res.kind = KIND_ERROR;
                            res.err  = ERR_BARE_QUOTE;
                            n_mode   = M_SKIP;
                        end else begin
                            n_mode = M_QUOTED;
                        end
                    end else begin
                        take = 1'b1;
                    end
                end
                M_QUOTED: begin
                    if (i_char_in == CH_QUOTE) begin
                        n_mode = M_PENDQ;
                    end else begin
                        take = 1'b1;
                    end
                end
                M_PENDQ: begin
                    if (i_char_in == CH_QUOTE) begin
                        n_mode = M_QUOTED;
                        take   = 1'b1;
                    end else if (i_char_in == CH_COMMA) begin
                        push     = 1'b1;
                        res.kind = KIND_FIELD;
                        clr      = 1'b1;
                    end else begin
                        push     = 1'b1;
                        res.kind = KIND_ERROR;
                        res.err  = ERR_AFTER_QUOTE;
                        n_mode   = M_SKIP;
                    end
                end
                M_CLOSED: begin
                    if (i_char_in == CH_COMMA) begin
                        push     = 1'b1;
                        res.kind = KIND_FIELD;
                        clr      = 1'b1;
                    end else begin
                        push     = 1'b1;
                        res.kind = KIND_ERROR;
                        res.err  = ERR_AFTER_QUOTE;
                        n_mode   = M_SKIP;
                    end
                end
                default: ;
            endcase
        end

        if (take) begin
            n_raw = 1'b1;
            if (ws) begin
                if (r_ce) begin
                    if (r_cnt >= CW'(PENDING_DEPTH)) begin
                        push     = 1'b1;
                        res.kind = KIND_ERROR;
                        res.err  = ERR_WS_OVERFLOW;
                        n_mode   = M_SKIP;
                    end else begin
                        we    = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end else begin
                push     = 1'b1;
                res.kind = KIND_CHAR;
                res.ch   = i_char_in;
                fcnt     = r_cnt;
                n_cnt    = '0;
                n_ce     = 1'b1;
            end
        end

        if (clr) begin
            n_mode = M_START;
            n_raw  = 1'b0;
            n_ce   = 1'b0;
            n_cnt  = '0;
        end
    end

    // no buffer write while the back may still read held whitespace
    assign o_stall = i_q_full || (we && (r_fl != '0));
    assign acc     = i_valid && !o_stall;

    assign o_push  = acc && push;
    assign o_res   = res;
    assign o_fcnt  = fcnt;
    assign o_we    = acc && we;
    assign o_waddr = r_cnt[AW-1:0];
    assign o_wdata = i_char_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_raw  <= 1'b0;
            r_ce   <= 1'b0;
            r_cnt  <= '0;
            r_fl   <= '0;
        end else begin
            if (acc) begin
                r_mode <= n_mode;
                r_raw  <= n_raw;
                r_ce   <= n_ce;
                r_cnt  <= n_cnt;
            end
            r_fl <= r_fl + FL_W'(o_push && (fcnt != '0)) - FL_W'(i_bk.flush_done);
        end
    end

endmodule

// ===== sv/cft_back.sv =====
// ----------------------------------------------------------------------------
// cft_back
// Pops commands, replays held whitespace from the buffer, then delivers the
// closing result of each command through the output register.
// ----------------------------------------------------------------------------
module cft_back
    import cft_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    localparam int CW = $clog2(PENDING_DEPTH + 1),
    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  t_res          i_q_res,
    input  logic [CW-1:0] i_q_fcnt,
    output logic          o_pop,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    input  logic [15:0]   i_rdata,
    output t_bk_status    o_bk,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_kind,
    output logic [15:0]   o_char_out,
    output logic [1:0]    o_error_code,
    output logic          o_last
);

    logic          r_act;
    logic          r_rd;
    logic [CW-1:0] r_left;
    logic [CW-1:0] r_idx;
    t_res          r_fin;

    logic          r_ov;
    t_res          r_out;
    logic          r_last;

    logic out_free;
    logic ld_ws;
    logic ld_fin;
    logic ld_direct;
    logic issue;

    assign out_free  = !r_ov || !i_stall;
    assign ld_ws     = r_act && r_rd && out_free;
    assign issue     = r_act && (r_left != '0) && (!r_rd || out_free);
    assign ld_fin    = r_act && !r_rd && (r_left == '0) && out_free;
    assign ld_direct = !r_act && !i_q_empty && (i_q_fcnt == '0) && out_free;
    assign o_pop     = !r_act && !i_q_empty && ((i_q_fcnt != '0) || out_free);

    assign o_re            = issue;
    assign o_raddr         = r_idx[AW-1:0];
    assign o_bk.flush_done = ld_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_rd  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (o_pop && (i_q_fcnt != '0)) begin
                r_act  <= 1'b1;
                r_left <= i_q_fcnt;
                r_idx  <= '0;
                r_fin  <= i_q_res;
            end else if (ld_fin) begin
                r_act <= 1'b0;
            end

            if (issue) begin
                r_idx  <= r_idx + CW'(1);
                r_left <= r_left - CW'(1);
                r_rd   <= 1'b1;
            end else if (ld_ws) begin
                r_rd <= 1'b0;
            end

            if (ld_ws) begin
                r_ov       <= 1'b1;
                r_out.kind <= KIND_CHAR;
                r_out.ch   <= i_rdata;
                r_out.err  <= '0;
                r_last     <= 1'b0;
            end else if (ld_fin) begin
                r_ov   <= 1'b1;
                r_out  <= r_fin;
                r_last <= 1'b1;
            end else if (ld_direct) begin
                r_ov   <= 1'b1;
                r_out  <= i_q_res;
                r_last <= 1'b1;
            end else if (out_free) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_kind       = r_out.kind;
    assign o_char_out   = r_out.ch;
    assign o_error_code = r_out.err;
    assign o_last       = r_last;

endmodule

// ===== sv/csv_field_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit
// Streaming CSV line tokenizer: trims whitespace from each field, resolves
// quoting and doubled quotes, and emits content, field-end, line-end and
// error items.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_command, i_char_in
//  result  | out       | o_valid / i_stall  | o_kind, o_char_out, o_error_code, o_last
//
//  one input item per cycle while the input is not stalled (see below); an item that
//  releases n held whitespace units keeps the back end busy: pop, n buffer reads
//  through the registered read port, then the closing result
//  reset is synchronous and clears parse state, queue and output register
//  the input stalls when the command queue is full, or when whitespace must
//  be buffered while earlier held whitespace is still being replayed
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit
    import cft_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [15:0] i_char_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_char_out,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int QW = $bits(t_res) + CW;

    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    t_res          f_res;
    logic [CW-1:0] f_fcnt;
    logic [QW-1:0] q_out;
    t_res          b_res;
    logic [CW-1:0] b_fcnt;
    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;
    t_bk_status    bk;

    cft_front #(
        .PENDING_DEPTH(PENDING_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .i_char_in (i_char_in),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_res     (f_res),
        .o_fcnt    (f_fcnt),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .i_bk      (bk)
    );

    cft_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_res, f_fcnt}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign b_res  = q_out[QW-1:CW];
    assign b_fcnt = q_out[CW-1:0];

    cft_ram #(
        .WIDTH(16),
        .DEPTH(PENDING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cft_back #(
        .PENDING_DEPTH(PENDING_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_res      (b_res),
        .i_q_fcnt     (b_fcnt),
        .o_pop        (pop),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_bk         (bk),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_char_out   (o_char_out),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

endmodule
